@@ sv/hbm_pkg.sv @@
// Shared types, constants and device tables of the heartbeat monitor.
`default_nettype none

package hbm_pkg;

	localparam int DEVICES  = 17;
	localparam int IDX_W    = $clog2(DEVICES);
	localparam int DEVICE_W = 5;
	localparam int NOW_W    = 32;
	localparam int CFG_W    = 17;
	localparam int CFG_IDX_W = 2;
	localparam int LIMIT_W  = 8;
	localparam int PRIO_W   = 4;
	localparam int CNT_W    = 9;

	typedef enum logic [1:0] {
		KIND_BEAT  = 2'd0,
		KIND_SCAN  = 2'd1,
		KIND_QUERY = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE_MASK = 2'd0,
		CFG_PAUSE_SCANS = 2'd1,
		CFG_HALF_SCANS  = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCAN,
		ST_BLINK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic capture;
		logic beat;
		logic visit;
		logic blink;
		logic emit;
	} hbm_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       scan_last;
		logic       out_free;
	} hbm_sts_t;

	localparam logic [LIMIT_W-1:0] OFFLINE_LIMIT [DEVICES] = '{
		8'd30, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10,
		8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd30
	};

	localparam logic [LIMIT_W-1:0] SETTLE_LIMIT [DEVICES] = '{
		8'd40, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10,
		8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd20
	};

	localparam logic [PRIO_W-1:0] DEVICE_PRIO [DEVICES] = '{
		4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7,
		4'd6, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd1
	};

endpackage

`default_nettype wire

@@ sv/hbm_if.sv @@
// Item channels of the heartbeat monitor: request and response.
`default_nettype none

interface hbm_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [4:0] device;
	logic       data_bad;
	logic [31:0] now;

	modport source (output valid, output kind, output device, output data_bad, output now,
		input ready);
	modport sink (input valid, input kind, input device, input data_bad, input now,
		output ready);
endinterface

interface hbm_rsp_if;
	logic       valid;
	logic       ready;
	logic       device_error;
	logic       any_lost;
	logic [4:0] shown_device;
	logic       led_on;

	modport source (output valid, output device_error, output any_lost, output shown_device,
		output led_on, input ready);
	modport sink (input valid, input device_error, input any_lost, input shown_device,
		input led_on, output ready);
endinterface

`default_nettype wire

@@ sv/hbm_ctrl.sv @@
// Sequencing state machine of the heartbeat monitor.
`default_nettype none

module hbm_ctrl
	import hbm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire hbm_sts_t sts,
	output hbm_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (sts.kind == KIND_SCAN) state_d = ST_SCAN;
				else state_d = ST_EMIT;
			end
			ST_SCAN: begin
				if (sts.scan_last) state_d = ST_BLINK;
			end
			ST_BLINK: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_EXEC: begin
				cmd.beat = (sts.kind == KIND_BEAT);
			end
			ST_SCAN: begin
				cmd.visit = 1'b1;
			end
			ST_BLINK: begin
				cmd.blink = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	a_scan_to_blink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && sts.scan_last) |=> cmd.blink)
		else $error("scan did not end in a blink step");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted into a full output register");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.beat, cmd.visit, cmd.blink, cmd.emit}))
		else $error("more than one datapath command at once");

endmodule

`default_nettype wire

@@ sv/hbm_dp.sv @@
// Datapath of the heartbeat monitor: device state, scan, blink code, result register.
`default_nettype none

module hbm_dp
	import hbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	hbm_req_if.sink                   req,
	hbm_rsp_if.source                 rsp,
	input  wire hbm_cmd_t             cmd,
	output hbm_sts_t                  sts
);

	logic [DEVICES-1:0]   enable_q;
	logic [7:0]           pause_scans_q;
	logic [7:0]           half_scans_q;

	logic [1:0]           kind_q;
	logic [DEVICE_W-1:0]  dev_q;
	logic                 bad_q;
	logic [NOW_W-1:0]     now_q;

	logic [NOW_W-1:0]     heard_q  [DEVICES];
	logic [NOW_W-1:0]     online_q [DEVICES];
	logic [DEVICES-1:0]   lost_q;
	logic [DEVICES-1:0]   error_q;
	logic [DEVICES-1:0]   data_err_q;

	logic [IDX_W-1:0]     idx_q;
	logic [DEVICE_W-1:0]  best_q;
	logic [PRIO_W-1:0]    best_prio_q;
	logic                 any_q;

	logic [DEVICE_W-1:0]  pulses_q;
	logic [CNT_W-1:0]     blink_pause_q;
	logic [CNT_W-1:0]     blink_half_q;
	logic                 phase_q;
	logic                 led_q;
	logic                 last_any_q;
	logic [DEVICE_W-1:0]  last_shown_q;

	logic                 out_valid_q;
	logic                 out_err_q;
	logic                 out_any_q;
	logic [DEVICE_W-1:0]  out_shown_q;
	logic                 out_led_q;

	logic [IDX_W-1:0]     dev_idx;
	logic                 dev_ok;
	logic [NOW_W-1:0]     since_heard;
	logic [NOW_W-1:0]     since_online;
	logic                 is_offline;
	logic                 is_settling;
	logic [DEVICE_W-1:0]  code;
	logic [CNT_W-1:0]     pause_inc;
	logic [CNT_W-1:0]     half_inc;

	assign dev_idx      = dev_q[IDX_W-1:0];
	assign dev_ok       = dev_q < DEVICE_W'(DEVICES);
	assign since_heard  = now_q - heard_q[idx_q];
	assign since_online = now_q - online_q[idx_q];
	assign is_offline   = since_heard > NOW_W'(OFFLINE_LIMIT[idx_q]);
	assign is_settling  = since_online < NOW_W'(SETTLE_LIMIT[idx_q]);
	assign code         = DEVICE_W'(best_q + 1'b1);
	assign pause_inc    = blink_pause_q + 1'b1;
	assign half_inc     = blink_half_q + 1'b1;

	assign sts.kind      = kind_q;
	assign sts.scan_last = (idx_q == IDX_W'(DEVICES - 1));
	assign sts.out_free  = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= '1;
			pause_scans_q <= 8'd50;
			half_scans_q  <= 8'd20;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ENABLE_MASK: enable_q      <= cfg_data[DEVICES-1:0];
				CFG_PAUSE_SCANS: pause_scans_q <= cfg_data[7:0];
				CFG_HALF_SCANS:  half_scans_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= req.kind;
			dev_q  <= req.device;
			bad_q  <= req.data_bad;
			now_q  <= req.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEVICES; i++) begin
				heard_q[i]  <= '0;
				online_q[i] <= '0;
			end
			lost_q     <= '1;
			error_q    <= '1;
			data_err_q <= '1;
		end else if (cmd.beat && dev_ok) begin
			heard_q[dev_idx] <= now_q;
			if (lost_q[dev_idx]) begin
				lost_q[dev_idx]   <= 1'b0;
				online_q[dev_idx] <= now_q;
			end
			data_err_q[dev_idx] <= bad_q;
			if (bad_q) error_q[dev_idx] <= 1'b1;
		end else if (cmd.visit && enable_q[idx_q]) begin
			priority if (is_offline) begin
				if (!error_q[idx_q]) begin
					lost_q[idx_q]  <= 1'b1;
					error_q[idx_q] <= 1'b1;
				end
			end else if (is_settling) begin
				lost_q[idx_q]  <= 1'b0;
				error_q[idx_q] <= 1'b1;
			end else begin
				lost_q[idx_q]  <= 1'b0;
				error_q[idx_q] <= data_err_q[idx_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			best_q      <= DEVICE_W'(DEVICES);
			best_prio_q <= '0;
			any_q       <= 1'b0;
		end else if (cmd.capture) begin
			idx_q       <= '0;
			best_q      <= DEVICE_W'(DEVICES);
			best_prio_q <= '0;
			any_q       <= 1'b0;
		end else if (cmd.visit) begin
			if (!sts.scan_last) idx_q <= idx_q + 1'b1;
			if (enable_q[idx_q] && is_offline) begin
				any_q <= 1'b1;
				if (DEVICE_PRIO[idx_q] > best_prio_q) begin
					best_prio_q <= DEVICE_PRIO[idx_q];
					best_q      <= DEVICE_W'(idx_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulses_q      <= '0;
			blink_pause_q <= '0;
			blink_half_q  <= '0;
			phase_q       <= 1'b0;
			led_q         <= 1'b0;
			last_any_q    <= 1'b0;
			last_shown_q  <= DEVICE_W'(DEVICES);
		end else if (cmd.blink) begin
			last_any_q   <= any_q;
			last_shown_q <= best_q;
			priority if (best_q == DEVICE_W'(DEVICES)) begin
				led_q <= 1'b0;
			end else if (pulses_q == '0) begin
				if (pause_inc > CNT_W'(pause_scans_q)) begin
					blink_pause_q <= '0;
					pulses_q      <= code;
				end else begin
					blink_pause_q <= pause_inc;
				end
			end else begin
				if (blink_half_q == '0) begin
					led_q   <= !led_q;
					phase_q <= !phase_q;
					if (phase_q) pulses_q <= pulses_q - 1'b1;
				end
				if (half_inc > CNT_W'(half_scans_q)) blink_half_q <= '0;
				else blink_half_q <= half_inc;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_err_q   <= dev_ok && error_q[dev_idx];
			out_any_q   <= last_any_q;
			out_shown_q <= last_shown_q;
			out_led_q   <= led_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.device_error = out_err_q;
	assign rsp.any_lost     = out_any_q;
	assign rsp.shown_device = out_shown_q;
	assign rsp.led_on       = out_led_q;

	a_shown_any: assert property (@(posedge clk) disable iff (!arst_n)
		last_any_q == (last_shown_q != DEVICE_W'(DEVICES)))
		else $error("lost summary disagrees with shown device");

	a_led_dark: assert property (@(posedge clk) disable iff (!arst_n)
		(last_shown_q == DEVICE_W'(DEVICES)) |-> !led_q)
		else $error("LED lit with no device shown");

	a_pulses_range: assert property (@(posedge clk) disable iff (!arst_n)
		pulses_q <= DEVICE_W'(DEVICES))
		else $error("blink pulse count beyond device count");

endmodule

`default_nettype wire

@@ sv/multi_device_heartbeat_monitor_core.sv @@
// Top level of the multi-device heartbeat monitor.
// Each request item (heartbeat, scan, query or no-op) yields exactly one response item that
// carries the addressed device's error flag, the last scan's lost summary, the shown device
// and the LED level. A heartbeat, query or no-op goes from capture through execute to emit,
// which loads the response register; a scan goes from execute through the scan, visiting one
// device per cycle through the per-device time stamps and flags, and one blink-code step to
// emit. A new request is taken as soon as the previous one is finished, even while its
// response still waits in the output register. Configuration writes are taken at any time.
`default_nettype none

module multi_device_heartbeat_monitor_core
	import hbm_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_idx,
	input  wire logic [CFG_W-1:0]     cfg_data,
	hbm_req_if.sink                   req,
	hbm_rsp_if.source                 rsp
);

	hbm_cmd_t cmd;
	hbm_sts_t sts;
	logic     ready;

	assign req.ready = ready;

	hbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	hbm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req),
		.rsp      (rsp),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

`default_nettype wire

@@ test/multi_device_heartbeat_monitor_core_test.sv @@
// Self-checking heartbeat monitor core testbench: random heartbeat, scan, query and no-op items checked against a predictor.
module multi_device_heartbeat_monitor_core_test;
	import hbm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_AFTER = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 215;

	localparam logic [7:0] OFF_TICKS [DEVICES] = '{
		8'd30, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10,
		8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd30
	};
	localparam logic [7:0] SETTLE_TICKS [DEVICES] = '{
		8'd40, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10,
		8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd20
	};
	localparam logic [3:0] PRIO_OF [DEVICES] = '{
		4'd15, 4'd14, 4'd13, 4'd12, 4'd11, 4'd10, 4'd9, 4'd8, 4'd7,
		4'd6, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd3, 4'd1
	};

	typedef struct {
		kind_t                 kind;
		logic [DEVICE_W-1:0]   device;
		logic                  data_bad;
		logic [NOW_W-1:0]      now;
	} hb_request_t;

	typedef struct {
		logic                  device_error;
		logic                  any_lost;
		logic [DEVICE_W-1:0]   shown_device;
		logic                  led_on;
	} hb_status_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_data;

	hbm_req_if req_ch();
	hbm_rsp_if rsp_ch();

	multi_device_heartbeat_monitor_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// predictor state
	logic [NOW_W-1:0]    heard_at [DEVICES];
	logic [NOW_W-1:0]    online_at [DEVICES];
	bit                  lost_q [DEVICES];
	bit                  err_q [DEVICES];
	bit                  data_err_q [DEVICES];
	logic [16:0]         scan_mask;
	logic [7:0]          dark_scans;
	logic [7:0]          half_scans;
	logic [4:0]          pulses_left;
	logic [CNT_W-1:0]    dark_count;
	logic [CNT_W-1:0]    half_count;
	bit                  phase_hi;
	bit                  led_q;
	bit                  last_any;
	logic [DEVICE_W-1:0] last_shown;

	hb_request_t pending_items[$];
	hb_status_t  status_due[$];
	hb_request_t offered;

	int items_queued = 0;
	int rsps_checked = 0;
	int mismatches = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_done = 0;
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;
	logic [NOW_W-1:0] tick;
	logic [16:0] live_devs;

	function automatic hb_status_t predict_status(hb_request_t r);
		hb_status_t s;
		bit known;
		logic [NOW_W-1:0] elapsed;
		logic [DEVICE_W-1:0] pick;
		logic [3:0] pick_prio;
		bit found;
		known = r.device < DEVICES;
		if (r.kind == KIND_BEAT && known) begin
			heard_at[r.device] = r.now;
			if (lost_q[r.device]) begin
				lost_q[r.device] = 1'b0;
				online_at[r.device] = r.now;
			end
			data_err_q[r.device] = r.data_bad;
			if (r.data_bad)
				err_q[r.device] = 1'b1;
		end else if (r.kind == KIND_SCAN) begin
			pick = 5'(DEVICES);
			pick_prio = '0;
			found = 1'b0;
			for (int i = 0; i < DEVICES; i++) begin
				if (scan_mask[i]) begin
					elapsed = r.now - heard_at[i];
					if (elapsed > 32'(OFF_TICKS[i])) begin
						if (!err_q[i]) begin
							lost_q[i] = 1'b1;
							err_q[i] = 1'b1;
						end
						if (PRIO_OF[i] > pick_prio) begin
							pick_prio = PRIO_OF[i];
							pick = 5'(i);
						end
						found = 1'b1;
					end else begin
						elapsed = r.now - online_at[i];
						lost_q[i] = 1'b0;
						err_q[i] = (elapsed < 32'(SETTLE_TICKS[i])) ? 1'b1 : data_err_q[i];
					end
				end
			end
			last_any = found;
			last_shown = pick;
			// blink code: index+1 pulses, then a dark pause
			if (pick == 5'(DEVICES)) begin
				led_q = 1'b0;
			end else if (pulses_left == 0) begin
				dark_count = dark_count + 9'd1;
				if (dark_count > 9'(dark_scans)) begin
					dark_count = '0;
					pulses_left = pick + 5'd1;
				end
			end else begin
				if (half_count == 0) begin
					led_q = !led_q;
					if (phase_hi) begin
						phase_hi = 1'b0;
						pulses_left = pulses_left - 5'd1;
					end else begin
						phase_hi = 1'b1;
					end
				end
				half_count = half_count + 9'd1;
				if (half_count > 9'(half_scans))
					half_count = '0;
			end
		end
		s.device_error = known ? err_q[r.device] : 1'b0;
		s.any_lost = last_any;
		s.shown_device = last_shown;
		s.led_on = led_q;
		return s;
	endfunction

	task automatic push_item(kind_t k, logic [DEVICE_W-1:0] dev, logic bad, logic [NOW_W-1:0] now);
		hb_request_t r;
		r.kind = k;
		r.device = dev;
		r.data_bad = bad;
		r.now = now;
		pending_items.push_back(r);
		items_queued++;
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		case (idx)
			CFG_ENABLE_MASK: scan_mask = value[16:0];
			CFG_PAUSE_SCANS: dark_scans = value[7:0];
			CFG_HALF_SCANS: half_scans = value[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (rsps_checked != items_queued)
			@(posedge clk);
	endtask

	task automatic add_random_items(int count);
		kind_t k;
		logic [DEVICE_W-1:0] dev;
		logic bad;
		int r;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				live_devs = '0;
				repeat ($urandom_range(6, 2))
					live_devs[$urandom_range(16, 0)] = 1'b1;
			end
			r = $urandom_range(999, 0);
			if (r < 10)
				tick = $urandom;
			else if (r < 15)
				tick = 32'hFFFF_FFC0 | 32'($urandom_range(63, 0));
			else if (r < 40)
				tick = tick + 32'($urandom_range(120, 12));
			else
				tick = tick + 32'($urandom_range(2, 0));
			r = $urandom_range(99, 0);
			bad = 1'($urandom_range(1, 0));
			dev = 5'($urandom_range(31, 0));
			if (r < 45) begin
				k = KIND_BEAT;
				bad = ($urandom_range(9, 0) == 0);
				if ($urandom_range(99, 0) < 85) begin
					do
						dev = 5'($urandom_range(16, 0));
					while (!live_devs[dev]);
				end
			end else if (r < 75) begin
				k = KIND_SCAN;
			end else if (r < 92) begin
				k = KIND_QUERY;
				if ($urandom_range(9, 0) != 0)
					dev = 5'($urandom_range(16, 0));
			end else begin
				k = KIND_NOP;
			end
			push_item(k, dev, bad, tick);
		end
	endtask

	task automatic check_field(string field, logic [4:0] want, logic [4:0] got);
		if (want !== got) begin
			if (mismatches < 100)
				$display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
			mismatches++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				status_due.push_back(predict_status(offered));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_items.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
					offered = pending_items.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.kind <= offered.kind;
					req_ch.device <= offered.device;
					req_ch.data_bad <= offered.data_bad;
					req_ch.now <= offered.now;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor
	always @(posedge clk or negedge arst_n) begin
		hb_status_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				rsps_checked <= rsps_checked + 1;
				if (status_due.size() == 0) begin
					if (mismatches < 100)
						$display("%0t ns: item with none expected, actual %b %b %0d %b", $time,
							rsp_ch.device_error, rsp_ch.any_lost, rsp_ch.shown_device,
							rsp_ch.led_on);
					mismatches++;
				end else begin
					want = status_due.pop_front();
					check_field("device_error", want.device_error, rsp_ch.device_error);
					check_field("any_lost", want.any_lost, rsp_ch.any_lost);
					check_field("shown_device", want.shown_device, rsp_ch.shown_device);
					check_field("led_on", want.led_on, rsp_ch.led_on);
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && rsps_checked == HOLD_AFTER) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99, 0) >= rsp_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [16:0] mask;
		logic [7:0] pause_val;
		logic [7:0] half_val;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = CFG_ENABLE_MASK;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_NOP;
		req_ch.device = '0;
		req_ch.data_bad = 1'b0;
		req_ch.now = '0;
		rsp_ch.ready = 1'b0;
		for (int i = 0; i < DEVICES; i++) begin
			heard_at[i] = '0;
			online_at[i] = '0;
			lost_q[i] = 1'b1;
			err_q[i] = 1'b1;
			data_err_q[i] = 1'b1;
		end
		scan_mask = 17'h1FFFF;
		dark_scans = 8'd50;
		half_scans = 8'd20;
		pulses_left = '0;
		dark_count = '0;
		half_count = '0;
		phase_hi = 1'b0;
		led_q = 1'b0;
		last_any = 1'b0;
		last_shown = 5'(DEVICES);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		push_item(KIND_QUERY, 5'd0, 1'b0, 32'd0);
		push_item(KIND_QUERY, 5'd17, 1'b0, 32'd0);
		push_item(KIND_QUERY, 5'd31, 1'b1, 32'd1);
		push_item(KIND_NOP, 5'd31, 1'b1, 32'hFFFF_FFFF);
		push_item(KIND_BEAT, 5'd31, 1'b0, 32'd3);
		push_item(KIND_BEAT, 5'd0, 1'b0, 32'd5);
		push_item(KIND_BEAT, 5'd16, 1'b1, 32'd6);
		push_item(KIND_BEAT, 5'd1, 1'b0, 32'd7);
		push_item(KIND_SCAN, 5'd0, 1'b0, 32'd10);
		push_item(KIND_SCAN, 5'd31, 1'b1, 32'd11);
		push_item(KIND_SCAN, 5'd0, 1'b0, 32'd50);
		push_item(KIND_BEAT, 5'd0, 1'b0, 32'd60);
		push_item(KIND_BEAT, 5'd0, 1'b0, 32'd85);
		push_item(KIND_SCAN, 5'd0, 1'b0, 32'd100);
		push_item(KIND_QUERY, 5'd0, 1'b0, 32'd100);
		push_item(KIND_SCAN, 5'd0, 1'b0, 32'd131);
		push_item(KIND_QUERY, 5'd0, 1'b0, 32'd131);
		push_item(KIND_BEAT, 5'd0, 1'b1, 32'hFFFF_FFF0);
		push_item(KIND_SCAN, 5'd0, 1'b0, 32'd5);
		push_item(KIND_QUERY, 5'd0, 1'b0, 32'd5);
		push_item(KIND_BEAT, 5'd16, 1'b0, 32'd8);
		push_item(KIND_SCAN, 5'd16, 1'b0, 32'hFFFF_FFFF);
		push_item(KIND_QUERY, 5'd16, 1'b1, 32'hFFFF_FFFF);
		wait_drained();

		tick = 32'd200;
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					mask = 17'h1FFFF;
					pause_val = 8'd1;
					half_val = 8'd1;
				end
				1: begin
					mask = 17'($urandom_range(17'h1FFFF, 0));
					pause_val = 8'd255;
					half_val = 8'd255;
				end
				2: begin
					mask = '0;
					pause_val = 8'($urandom_range(4, 1));
					half_val = 8'($urandom_range(4, 1));
				end
				3: begin
					mask = 17'($urandom_range(17'h1FFFF, 0) | $urandom_range(17'h1FFFF, 0));
					pause_val = 8'd255;
					half_val = 8'd1;
				end
				4: begin
					mask = 17'h1FFFF;
					pause_val = 8'd1;
					half_val = 8'd255;
				end
				default: begin
					mask = 17'($urandom_range(17'h1FFFF, 0) | $urandom_range(17'h1FFFF, 0));
					pause_val = 8'($urandom_range(6, 1));
					half_val = 8'($urandom_range(3, 1));
				end
			endcase
			write_reg(CFG_ENABLE_MASK, CFG_W'(mask));
			write_reg(CFG_PAUSE_SCANS, CFG_W'(pause_val));
			write_reg(CFG_HALF_SCANS, CFG_W'(half_val));
			if (p == 0)
				write_reg(CFG_UNUSED, CFG_W'($urandom_range(17'h1FFFF, 0)));
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 71;
					rsp_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					rsp_stall_pct = 71;
				end
				default: begin
					send_idle_pct = 6;
					rsp_stall_pct = 6;
				end
			endcase
			add_random_items(PHASE_ITEMS);
			wait_drained();
		end

		repeat (30) @(posedge clk);
		if (mismatches == 0 && status_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
